>>> hw/rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape core.
// Depends on nothing; used by jsu_decode, jsu_out and the top level.
package jsu_pkg;

   // Decoder phase codes
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_BODY       = 3'd1;
   localparam logic [2:0] PH_ESC        = 3'd2;
   localparam logic [2:0] PH_HEX        = 3'd3;
   localparam logic [2:0] PH_DONE       = 3'd4;
   localparam logic [2:0] PH_ERR_ESC    = 3'd5;
   localparam logic [2:0] PH_ERR_QUOTE  = 3'd6;
   localparam logic [2:0] PH_ERR_UNTERM = 3'd7;

   // Reported status codes
   localparam logic [2:0] ST_RUNNING    = 3'd0;
   localparam logic [2:0] ST_CLOSED     = 3'd1;
   localparam logic [2:0] ST_BAD_ESC    = 3'd2;
   localparam logic [2:0] ST_NO_QUOTE   = 3'd3;
   localparam logic [2:0] ST_UNTERM     = 3'd4;

   // Characters of interest
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_N          = 8'h6E;
   localparam logic [7:0] CH_T          = 8'h74;
   localparam logic [7:0] CH_R          = 8'h72;
   localparam logic [7:0] CH_B          = 8'h62;
   localparam logic [7:0] CH_F          = 8'h66;
   localparam logic [7:0] CH_U          = 8'h75;
   localparam logic [7:0] CTL_LF        = 8'h0A;
   localparam logic [7:0] CTL_TAB       = 8'h09;
   localparam logic [7:0] CTL_CR        = 8'h0D;
   localparam logic [7:0] CTL_BS        = 8'h08;
   localparam logic [7:0] CTL_FF        = 8'h0C;

   // UTF-8 encoding constants
   localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
   localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF_CONT     = 8'h80;
   localparam logic [7:0]  UTF_CONT_MSK = 8'h3F;

   // All results caused by one input byte
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;     // number of result beats, 1 to 3
      logic       has_byte;
      logic [2:0] status;
   } run_type;

endpackage

>>> hw/rtl/jsu_decode.sv
// Decoder state machine and UTF-8 encoder for one input byte.
// Depends on jsu_pkg; updates its state when the held byte advances.
module jsu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  logic                end_of_text,
   output jsu_pkg::run_type    run
);

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;
   logic        hex_stopped_ff, hex_stopped_in;
   logic [1:0]  n_bytes;
   logic [7:0]  b0, b1, b2;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [2:0]  status;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      hex_count_in   = hex_count_ff;
      code_point_in  = code_point_ff;
      hex_stopped_in = hex_stopped_ff;
      n_bytes        = 2'd0;
      b0             = 8'd0;
      b1             = 8'd0;
      b2             = 8'd0;
      unique case (phase_ff)
         jsu_pkg::PH_IDLE: begin
            phase_in = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY
                                                      : jsu_pkg::PH_ERR_QUOTE;
         end
         jsu_pkg::PH_BODY: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               phase_in = jsu_pkg::PH_DONE;
            end else if (in_byte == jsu_pkg::CH_BACKSLASH && !end_of_text) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               // a backslash on the last byte passes as a literal
               n_bytes = 2'd1;
               b0      = in_byte;
            end
         end
         jsu_pkg::PH_ESC: begin
            phase_in = jsu_pkg::PH_BODY;
            n_bytes  = 2'd1;
            unique case (in_byte)
               jsu_pkg::CH_QUOTE:     b0 = jsu_pkg::CH_QUOTE;
               jsu_pkg::CH_BACKSLASH: b0 = jsu_pkg::CH_BACKSLASH;
               jsu_pkg::CH_SLASH:     b0 = jsu_pkg::CH_SLASH;
               jsu_pkg::CH_N:         b0 = jsu_pkg::CTL_LF;
               jsu_pkg::CH_T:         b0 = jsu_pkg::CTL_TAB;
               jsu_pkg::CH_R:         b0 = jsu_pkg::CTL_CR;
               jsu_pkg::CH_B:         b0 = jsu_pkg::CTL_BS;
               jsu_pkg::CH_F:         b0 = jsu_pkg::CTL_FF;
               jsu_pkg::CH_U: begin
                  n_bytes        = 2'd0;
                  hex_count_in   = 2'd0;
                  code_point_in  = 16'd0;
                  hex_stopped_in = 1'b0;
                  phase_in       = jsu_pkg::PH_HEX;
               end
               default: begin
                  n_bytes  = 2'd0;
                  phase_in = jsu_pkg::PH_ERR_ESC;
               end
            endcase
         end
         jsu_pkg::PH_HEX: begin
            // only leading hex digits count; all four bytes are consumed
            if (!hex_stopped_ff && hex_ok) begin
               code_point_in = {code_point_ff[11:0], hex_val};
            end else begin
               hex_stopped_in = 1'b1;
            end
            if (hex_count_ff == 2'd3) begin
               if (code_point_in < jsu_pkg::CP_ONE_LIMIT) begin
                  n_bytes = 2'd1;
                  b0      = code_point_in[7:0];
               end else if (code_point_in < jsu_pkg::CP_TWO_LIMIT) begin
                  n_bytes = 2'd2;
                  b0      = jsu_pkg::UTF_LEAD2 | {3'd0, code_point_in[10:6]};
                  b1      = jsu_pkg::UTF_CONT |
                            (code_point_in[7:0] & jsu_pkg::UTF_CONT_MSK);
               end else begin
                  n_bytes = 2'd3;
                  b0      = jsu_pkg::UTF_LEAD3 | {4'd0, code_point_in[15:12]};
                  b1      = jsu_pkg::UTF_CONT |
                            (code_point_in[13:6] & jsu_pkg::UTF_CONT_MSK);
                  b2      = jsu_pkg::UTF_CONT |
                            (code_point_in[7:0] & jsu_pkg::UTF_CONT_MSK);
               end
               hex_count_in   = 2'd0;
               code_point_in  = 16'd0;
               hex_stopped_in = 1'b0;
               phase_in       = jsu_pkg::PH_BODY;
            end else begin
               hex_count_in = hex_count_ff + 2'd1;
            end
         end
         default: begin
            // final phases hold until reset
         end
      endcase

      if (end_of_text && (phase_in == jsu_pkg::PH_BODY ||
                          phase_in == jsu_pkg::PH_ESC ||
                          phase_in == jsu_pkg::PH_HEX)) begin
         phase_in = jsu_pkg::PH_ERR_UNTERM;
      end
   end

   always_comb begin
      unique case (phase_in)
         jsu_pkg::PH_DONE:       status = jsu_pkg::ST_CLOSED;
         jsu_pkg::PH_ERR_ESC:    status = jsu_pkg::ST_BAD_ESC;
         jsu_pkg::PH_ERR_QUOTE:  status = jsu_pkg::ST_NO_QUOTE;
         jsu_pkg::PH_ERR_UNTERM: status = jsu_pkg::ST_UNTERM;
         default:                status = jsu_pkg::ST_RUNNING;
      endcase
   end

   assign run.byte0    = b0;
   assign run.byte1    = b1;
   assign run.byte2    = b2;
   assign run.count    = (n_bytes == 2'd0) ? 2'd1 : n_bytes;
   assign run.has_byte = (n_bytes != 2'd0);
   assign run.status   = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= jsu_pkg::PH_IDLE;
         hex_count_ff   <= 2'd0;
         code_point_ff  <= 16'd0;
         hex_stopped_ff <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         hex_count_ff   <= hex_count_in;
         code_point_ff  <= code_point_in;
         hex_stopped_ff <= hex_stopped_in;
      end
   end

endmodule

>>> hw/rtl/jsu_out.sv
// Result register: holds the beats of one input byte and sends them in order.
// Depends on jsu_pkg for the run type.
module jsu_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jsu_pkg::run_type    run_in,
   output logic                run_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_last_of_run
);

   jsu_pkg::run_type run_ff;
   logic             valid_ff;
   logic             last;
   logic             beat;

   assign last     = (run_ff.count == 2'd1);
   assign beat     = valid_ff && rsp_ready;
   assign run_free = !valid_ff || (beat && last);

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = run_ff.byte0;
   assign rsp_byte_valid  = run_ff.has_byte;
   assign rsp_status      = last ? run_ff.status : jsu_pkg::ST_RUNNING;
   assign rsp_last_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (beat && last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run_in;
      end else if (beat && !last) begin
         // advance to the next byte of a multi-byte sequence
         run_ff.byte0 <= run_ff.byte1;
         run_ff.byte1 <= run_ff.byte2;
         run_ff.count <= run_ff.count - 2'd1;
      end
   end

endmodule

>>> hw/rtl/json_string_unescape_utf8_core.sv
// Accepted input bytes pass the input register, then the result register.
// Throughput: one input byte per cycle while rsp_ready is high; a byte
// that decodes to a \u escape of two or three UTF-8 bytes holds the result
// register for that many beats. Reset (synchronous, active high) returns
// the decoder to awaiting the opening quote and empties the input and
// result registers. Depends on jsu_pkg, jsu_decode and jsu_out.
module json_string_unescape_utf8_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_last_of_run
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             eot_ff;
   logic             run_free;
   logic             advance;
   logic             req_beat;
   jsu_pkg::run_type run;

   assign advance   = in_valid_ff && run_free;
   assign req_ready = !in_valid_ff || run_free;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      priority if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_in_byte;
         eot_ff     <= req_end_of_text;
      end
   end

   jsu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (in_byte_ff),
      .end_of_text (eot_ff),
      .run         (run)
   );

   jsu_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .run_in          (run),
      .run_free        (run_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> tb/json_string_unescape_utf8_core_tb.sv
// Self-checking testbench for json_string_unescape_utf8_core: a directed table, then random
// string bodies. An in-module decoder predicts beats the typed rows do not give. Needs jsu_pkg and the RTL.
module json_string_unescape_utf8_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jsu_pkg::*;

   localparam int N_DIR    = 25;
   localparam int N_RANDOM = 425;
   localparam int N_HOLD   = 16;
   localparam int LIMIT    = 100000;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic [2:0] status;
      logic       last;
   } dec_beat_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       eot;
      logic       typed;
      logic [7:0] out_byte;
      logic       has_byte;
      logic [2:0] status;
   } text_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic [2:0] rsp_status;
   logic       rsp_last_of_run;

   json_string_unescape_utf8_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Decoder state mirrored from the block
   logic [2:0]  str_phase = PH_IDLE;
   logic [1:0]  hex_taken = 2'd0;
   logic [15:0] cp_acc = 16'h0000;
   logic        hex_done = 1'b0;

   dec_beat_type step_beats [0:2];
   int           step_n;
   dec_beat_type decoded_q [$];

   bit          idle_on = 1'b0;
   int          errors = 0;
   int          beats_checked = 0;
   int          items_sent = 0;
   int          n_simple = 0;
   int          n_unicode = 0;
   int          cycles = 0;
   int          ready_hold = 0;
   string       end_desc = "none";

   logic [7:0]  esc_chars [0:7] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_N,
                                    CH_T, CH_R, CH_B, CH_F};
   logic [15:0] cp_edges [0:7] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

   text_row_type dir_rows [0:N_DIR-1] = '{
      '{CH_QUOTE,     1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{8'h00,        1'b0, 1'b1, 8'h00,        1'b1, ST_RUNNING},
      '{8'hFF,        1'b0, 1'b1, 8'hFF,        1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_QUOTE,     1'b0, 1'b1, CH_QUOTE,     1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, CH_BACKSLASH, 1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_SLASH,     1'b0, 1'b1, CH_SLASH,     1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_N,         1'b0, 1'b1, CTL_LF,       1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_T,         1'b0, 1'b1, CTL_TAB,      1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_R,         1'b0, 1'b1, CTL_CR,       1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_B,         1'b0, 1'b1, CTL_BS,       1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_F,         1'b0, 1'b1, CTL_FF,       1'b1, ST_RUNNING},
      '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{CH_U,         1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{8'h46,        1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{8'h66,        1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{8'h46,        1'b0, 1'b1, 8'h00,        1'b0, ST_RUNNING},
      '{8'h66,        1'b0, 1'b0, 8'h00,        1'b0, ST_RUNNING}
   };

   function automatic logic is_hex_digit(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic logic is_escape_char(input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 8; k++)
         if (esc_chars[k] == b) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) return 8'h30 + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   // Append one expected beat to the tail of the queue
   function automatic void queue_beat(input dec_beat_type bt);
      decoded_q = {decoded_q, bt};
   endfunction

   // Decode one text byte: advance the mirrored state, fill step_beats
   function automatic void unescape_step(input logic [7:0] b, input logic eot);
      logic [7:0] enc [0:2];
      logic [3:0] nib;
      logic [2:0] st;
      int         n;
      n = 0;
      case (str_phase)
         PH_IDLE: str_phase = (b == CH_QUOTE) ? PH_BODY : PH_ERR_QUOTE;
         PH_BODY: begin
            if (b == CH_QUOTE) str_phase = PH_DONE;
            else if (b == CH_BACKSLASH && !eot) str_phase = PH_ESC;
            else begin
               enc[0] = b;
               n = 1;
            end
         end
         PH_ESC: begin
            str_phase = PH_BODY;
            n = 1;
            case (b)
               CH_QUOTE:     enc[0] = CH_QUOTE;
               CH_BACKSLASH: enc[0] = CH_BACKSLASH;
               CH_SLASH:     enc[0] = CH_SLASH;
               CH_N:         enc[0] = CTL_LF;
               CH_T:         enc[0] = CTL_TAB;
               CH_R:         enc[0] = CTL_CR;
               CH_B:         enc[0] = CTL_BS;
               CH_F:         enc[0] = CTL_FF;
               CH_U: begin
                  n = 0;
                  hex_taken = 2'd0;
                  cp_acc = 16'h0000;
                  hex_done = 1'b0;
                  str_phase = PH_HEX;
               end
               default: begin
                  n = 0;
                  str_phase = PH_ERR_ESC;
               end
            endcase
         end
         PH_HEX: begin
            if (b >= 8'h30 && b <= 8'h39) nib = b[3:0];
            else nib = b[3:0] + 4'd9;
            // the first non-hex byte freezes the code point for the rest of the escape
            if (!hex_done && is_hex_digit(b)) cp_acc = {cp_acc[11:0], nib};
            else hex_done = 1'b1;
            if (hex_taken == 2'd3) begin
               if (cp_acc < CP_ONE_LIMIT) begin
                  enc[0] = cp_acc[7:0];
                  n = 1;
               end else if (cp_acc < CP_TWO_LIMIT) begin
                  enc[0] = UTF_LEAD2 | {3'b000, cp_acc[10:6]};
                  enc[1] = UTF_CONT | ({2'b00, cp_acc[5:0]} & UTF_CONT_MSK);
                  n = 2;
               end else begin
                  enc[0] = UTF_LEAD3 | {4'h0, cp_acc[15:12]};
                  enc[1] = UTF_CONT | {2'b00, cp_acc[11:6]};
                  enc[2] = UTF_CONT | {2'b00, cp_acc[5:0]};
                  n = 3;
               end
               hex_taken = 2'd0;
               cp_acc = 16'h0000;
               hex_done = 1'b0;
               str_phase = PH_BODY;
            end else begin
               hex_taken = hex_taken + 2'd1;
            end
         end
         default: ;
      endcase
      if (eot && (str_phase == PH_BODY || str_phase == PH_ESC || str_phase == PH_HEX))
         str_phase = PH_ERR_UNTERM;
      case (str_phase)
         PH_DONE:       st = ST_CLOSED;
         PH_ERR_ESC:    st = ST_BAD_ESC;
         PH_ERR_QUOTE:  st = ST_NO_QUOTE;
         PH_ERR_UNTERM: st = ST_UNTERM;
         default:       st = ST_RUNNING;
      endcase
      if (n == 0) begin
         step_beats[0] = '{8'h00, 1'b0, st, 1'b1};
         step_n = 1;
      end else begin
         for (int k = 0; k < n; k++)
            step_beats[k] = '{enc[k], 1'b1, (k == n - 1) ? st : ST_RUNNING, k == n - 1};
         step_n = n;
      end
   endfunction

   // Send one text byte; typed rows replace the predicted beat
   task automatic push_text_byte(input logic [7:0] b, input logic eot,
                                 input logic typed, input dec_beat_type typed_beat);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      unescape_step(b, eot);
      if (typed) queue_beat(typed_beat);
      else for (int k = 0; k < step_n; k++) queue_beat(step_beats[k]);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_unicode_escape(output int sent);
      logic [15:0] cp;
      logic [7:0]  b;
      int          mode;
      int          stop_at;
      int          k;
      mode = $urandom_range(0, 3);
      cp = 16'($urandom);
      if (mode == 1) cp = cp_edges[$urandom_range(0, 7)];
      stop_at = (mode == 2) ? $urandom_range(0, 3) : 4;
      push_text_byte(CH_BACKSLASH, 1'b0, 1'b0, '0);
      push_text_byte(CH_U, 1'b0, 1'b0, '0);
      for (k = 0; k < 4; k++) begin
         if (mode == 3) b = 8'($urandom_range(0, 255));
         else if (k < stop_at) b = hex_char(cp[15 - 4 * k -: 4], 1'($urandom_range(0, 1)));
         else if (k == stop_at) begin
            do b = 8'($urandom_range(0, 255)); while (is_hex_digit(b));
         end else b = 8'($urandom_range(0, 255));
         push_text_byte(b, 1'b0, 1'b0, '0);
      end
      n_unicode++;
      sent = 6;
   endtask

   // Result side: random backpressure bursts
   always @(posedge clock) begin
      if (!idle_on) begin
         ready_hold <= 0;
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready <= (ready_hold == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         ready_hold <= $urandom_range(1, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_out
      dec_beat_type got;
      dec_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_byte, rsp_byte_valid, rsp_status, rsp_last_of_run};
         if (decoded_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: byte %02h valid %0b status %0d last %0b",
                        got.data, got.has_byte, got.status, got.last);
         end else begin
            want = decoded_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at beat %0d: expected byte %02h valid %0b status %0d last %0b",
                           beats_checked, want.data, want.has_byte, want.status, want.last);
                  $display("   got byte %02h valid %0b status %0d last %0b",
                           got.data, got.has_byte, got.status, got.last);
               end
            end
            beats_checked++;
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     decoded_q.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] b;
      int         k;
      int         body_sent;
      int         sent;
      int         pick;
      logic       paused;
      body_sent = 0;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      for (k = 0; k < N_DIR; k++)
         push_text_byte(dir_rows[k].in_byte, dir_rows[k].eot, dir_rows[k].typed,
                        '{dir_rows[k].out_byte, dir_rows[k].has_byte, dir_rows[k].status,
                          1'b1});

      while (body_sent < N_RANDOM) begin
         // calm stretch every third window and at the tail
         idle_on = (body_sent < N_RANDOM - 60) && ((body_sent / 50) % 3 != 2);
         if (!paused && body_sent >= N_RANDOM / 2) begin
            // drain the result side before sending more
            req_valid <= 1'b0;
            @(posedge clock);
            while (decoded_q.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
            push_text_byte(b, 1'b0, 1'b0, '0);
            sent = 1;
         end else if (pick < 70) begin
            push_text_byte(CH_BACKSLASH, 1'b0, 1'b0, '0);
            push_text_byte(esc_chars[$urandom_range(0, 7)], 1'b0, 1'b0, '0);
            n_simple++;
            sent = 2;
         end else begin
            send_unicode_escape(sent);
         end
         body_sent += sent;
      end

      idle_on = 1'b0;
      case ($urandom_range(0, 4))
         0: begin
            end_desc = "closing quote";
            push_text_byte(CH_QUOTE, 1'($urandom_range(0, 1)), 1'b0, '0);
         end
         1: begin
            end_desc = "bad escape";
            push_text_byte(CH_BACKSLASH, 1'b0, 1'b0, '0);
            do b = 8'($urandom_range(0, 255)); while (is_escape_char(b) || b == CH_U);
            push_text_byte(b, 1'b0, 1'b0, '0);
         end
         2: begin
            end_desc = "end of text in body";
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
            push_text_byte(b, 1'b1, 1'b0, '0);
         end
         3: begin
            end_desc = "backslash on last byte";
            push_text_byte(CH_BACKSLASH, 1'b1, 1'b0, '0);
         end
         default: begin
            end_desc = "end of text inside unicode escape";
            push_text_byte(CH_BACKSLASH, 1'b0, 1'b0, '0);
            push_text_byte(CH_U, 1'b0, 1'b0, '0);
            repeat ($urandom_range(0, 3))
               push_text_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                              1'b0, 1'b0, '0);
            push_text_byte(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b1, 1'b0, '0);
         end
      endcase

      // final status must hold for anything that follows
      for (k = 0; k < N_HOLD; k++)
         push_text_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      req_valid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d text bytes: %0d simple escapes, %0d unicode escapes, ending on %s.",
               items_sent, n_simple, n_unicode, end_desc);
      $display("Checked %0d result beats, %0d mismatches.", beats_checked, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
